// ----- hdl/eps_pkg.sv -----
// Shared types, codes and result formatting for the EPROM program sequencer.
`timescale 1ns / 1ps

package eps_pkg;

  localparam int unsigned AddrW   = 16;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned OpW     = 3;
  localparam int unsigned ActW    = 3;
  localparam int unsigned TypeW   = 3;
  localparam int unsigned NibW    = 4;
  localparam int unsigned AttW    = 5;
  localparam int unsigned MsW     = 6;
  localparam int unsigned QDepth  = 4;
  localparam int unsigned QPtrW   = 2;
  localparam int unsigned QCntW   = 3;

  localparam logic [TypeW-1:0] Type27128 = 3'd1;
  localparam logic [TypeW-1:0] Type27256 = 3'd2;
  localparam logic [TypeW-1:0] Type27512 = 3'd3;
  localparam logic [TypeW-1:0] TypeUnknown = 3'd4;

  localparam logic [NibW-1:0] Forced27256 = 4'h8;
  localparam logic [NibW-1:0] ForcedOther = 4'hc;
  localparam logic [NibW-1:0] Forced27512 = 4'h0;

  localparam logic [MsW-1:0] MsMax = 6'd63;

  typedef enum logic [OpW-1:0] {
    OpSeek   = 3'd0,
    OpNext   = 3'd1,
    OpRead   = 3'd2,
    OpWrite  = 3'd3,
    OpSample = 3'd4,
    OpTick   = 3'd5
  } opcode_e;

  typedef enum logic [ActW-1:0] {
    ActAddr   = 3'd0,
    ActRead   = 3'd1,
    ActVerify = 3'd2,
    ActOn     = 3'd3,
    ActOff    = 3'd4,
    ActDone   = 3'd5
  } action_e;

  typedef enum logic [5:0] {
    PhIdle   = 6'b000001,
    PhRead   = 6'b000010,
    PhCheck  = 6'b000100,
    PhPulse  = 6'b001000,
    PhVerify = 6'b010000,
    PhOver   = 6'b100000
  } phase_e;

  typedef enum logic [1:0] {
    ClsSmall   = 2'd0,
    ClsLarge   = 2'd1,
    ClsUnknown = 2'd2
  } type_class_e;

  typedef struct packed {
    action_e          action;
    logic [ByteW-1:0] drive_data;
    logic [AddrW-1:0] address_out;
    logic [NibW-1:0]  high_port;
    logic             chip_enable_n;
    logic             output_enable_n;
    logic             program_n;
    logic [ByteW-1:0] result_byte;
    logic             failed;
    logic             last_of_run;
  } result_t;

  typedef struct packed {
    logic [1:0] push_cnt;
    logic       pop;
  } q_ctrl_t;

  function automatic type_class_e type_class(input logic [TypeW-1:0] dev);
    type_class_e cls;
    if (dev <= Type27128) begin
      cls = ClsSmall;
    end else if (dev <= Type27512) begin
      cls = ClsLarge;
    end else begin
      cls = ClsUnknown;
    end
    return cls;
  endfunction

  function automatic logic [NibW-1:0] forced_bits(input logic [TypeW-1:0] dev);
    logic [NibW-1:0] f;
    if (dev == Type27512) begin
      f = Forced27512;
    end else if (dev == Type27256) begin
      f = Forced27256;
    end else begin
      f = ForcedOther;
    end
    return f;
  endfunction

  function automatic result_t make_result(
    input action_e          act,
    input logic [TypeW-1:0] dev,
    input logic [AddrW-1:0] addr,
    input logic [ByteW-1:0] wanted,
    input logic [ByteW-1:0] res_byte,
    input logic             fail,
    input logic             last
  );
    result_t     r;
    type_class_e cls;
    cls = type_class(dev);
    r.action          = act;
    r.drive_data      = '0;
    r.address_out     = addr;
    r.high_port       = addr[AddrW-1 -: NibW] | forced_bits(dev);
    r.chip_enable_n   = 1'b1;
    r.output_enable_n = 1'b1;
    r.program_n       = 1'b1;
    r.result_byte     = res_byte;
    r.failed          = fail;
    r.last_of_run     = last;
    case (act)
      ActRead: begin
        r.chip_enable_n   = 1'b0;
        r.output_enable_n = 1'b0;
      end
      ActOn: begin
        r.drive_data = wanted;
        if (cls == ClsSmall) begin
          r.chip_enable_n = 1'b0;
          r.program_n     = 1'b0;
        end else if (cls == ClsLarge) begin
          r.chip_enable_n = 1'b0;
        end
      end
      ActOff: begin
        r.drive_data = wanted;
        if (cls == ClsSmall) begin
          r.chip_enable_n = 1'b0;
        end
      end
      ActVerify: begin
        if (cls != ClsUnknown) begin
          r.chip_enable_n   = 1'b0;
          r.output_enable_n = 1'b0;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/eps_if.sv -----
// Valid/ready channel interfaces for sequencer commands and results.
`timescale 1ns / 1ps

interface eps_cmd_if;
  import eps_pkg::*;

  logic             valid;
  logic             ready;
  logic [OpW-1:0]   opcode;
  logic [AddrW-1:0] target_address;
  logic [ByteW-1:0] data_byte;

  modport source (output valid, output opcode, output target_address, output data_byte,
                  input ready);
  modport sink (input valid, input opcode, input target_address, input data_byte,
                output ready);
endinterface

interface eps_res_if;
  import eps_pkg::*;

  logic             valid;
  logic             ready;
  logic [ActW-1:0]  action;
  logic [ByteW-1:0] drive_data;
  logic [AddrW-1:0] address_out;
  logic [NibW-1:0]  high_port;
  logic             chip_enable_n;
  logic             output_enable_n;
  logic             program_n;
  logic [ByteW-1:0] result_byte;
  logic             failed;
  logic             last_of_run;

  modport source (output valid, output action, output drive_data, output address_out,
                  output high_port, output chip_enable_n, output output_enable_n,
                  output program_n, output result_byte, output failed,
                  output last_of_run, input ready);
  modport sink (input valid, input action, input drive_data, input address_out,
                input high_port, input chip_enable_n, input output_enable_n,
                input program_n, input result_byte, input failed,
                input last_of_run, output ready);
endinterface

// ----- hdl/eps_result_queue.sv -----
// Four-entry result queue that takes up to two results per cycle and gives one.
`timescale 1ns / 1ps

module eps_result_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  eps_pkg::q_ctrl_t        ctrl_i,
  input  eps_pkg::result_t        push0_i,
  input  eps_pkg::result_t        push1_i,
  output eps_pkg::result_t        head_o,
  output logic [eps_pkg::QCntW-1:0] count_o
);
  import eps_pkg::*;

  result_t          mem [QDepth];
  logic [QPtrW-1:0] wr_q, wr_d;
  logic [QPtrW-1:0] rd_q, rd_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_d  = wr_q + ctrl_i.push_cnt;
    rd_d  = rd_q + QPtrW'(ctrl_i.pop);
    cnt_d = cnt_q + QCntW'(ctrl_i.push_cnt) - QCntW'(ctrl_i.pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push_cnt != 2'd0) begin
      mem[wr_q] <= push0_i;
    end
    if (ctrl_i.push_cnt == 2'd2) begin
      mem[wr_q + QPtrW'(1)] <= push1_i;
    end
  end

  assign head_o  = mem[rd_q];
  assign count_o = cnt_q;

endmodule

// ----- hdl/eprom_program_sequencer.sv -----
// Top level of the EPROM program sequencer: command register, control logic, result queue.
`timescale 1ns / 1ps

// EPROM program sequencer. Commands (seek, next, read, write), bus samples and
// one-millisecond ticks arrive as beats on cmd_i; strobe actions for a byte-wide
// EPROM leave as beats on res_o. A write first reads the cell and finishes at once
// if it already holds the wanted byte; otherwise it issues 1 ms program pulses,
// each followed by a verify strobe, up to MAX_ATTEMPTS-1 pulses, then an
// overprogram pulse of OVERPROGRAM_FACTOR times the pulse count in ms (capped at
// 63 ms). A command beat is taken every cycle while the result queue has room;
// it is held in the command register, decoded in a single pass once the queue
// can absorb two results, and its results are written into the result queue.
// Results leave at one beat per cycle, while res_o.ready is high, through a four-entry
// queue, so the single result port sets the sustained rate: a tick beat that ends a
// pulse gives two results, any other beat at most one. Commands and samples that
// do not apply in the current phase, and ticks that do not end a pulse, give no result.
// Write device_type on cfg_we_i/cfg_wdata_i only while no work is outstanding.
module eprom_program_sequencer #(
  parameter int unsigned MAX_ATTEMPTS       = 16,
  parameter int unsigned OVERPROGRAM_FACTOR = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  eps_cmd_if.sink                   cmd_i,
  eps_res_if.source                 res_o,
  input  logic                      cfg_we_i,
  input  logic [eps_pkg::TypeW-1:0] cfg_wdata_i
);
  import eps_pkg::*;

  localparam int unsigned LenW = AttW + $clog2(OVERPROGRAM_FACTOR) + 1;

  // Command register
  logic             s1_valid_q;
  opcode_e          s1_op_q;
  logic [AddrW-1:0] s1_tgt_q;
  logic [ByteW-1:0] s1_dat_q;
  logic             cmd_fire;
  logic             s1_fire;

  // Sequencer state
  logic [TypeW-1:0] dev_q;
  logic [AddrW-1:0] addr_q, addr_d;
  phase_e           phase_q, phase_d;
  logic [AttW-1:0]  att_q, att_d;
  logic [MsW-1:0]   ms_q, ms_d;
  logic [ByteW-1:0] wanted_q, wanted_d;
  logic [ByteW-1:0] sample_q, sample_d;

  // Result path
  result_t          r0, r1;
  logic [1:0]       n_res;
  q_ctrl_t          q_ctrl;
  result_t          head;
  logic [QCntW-1:0] q_count;
  logic [QCntW-1:0] q_after_pop;
  logic             pop;

  logic [ByteW-1:0] verify_byte;
  logic [LenW-1:0]  over_len;
  logic [MsW-1:0]   over_ms;
  logic             give_up;

  assign pop         = res_o.valid && res_o.ready;
  assign q_after_pop = q_count - QCntW'(pop);
  // Decode only when the queue can absorb the worst case of two results.
  assign s1_fire     = s1_valid_q && (q_after_pop <= QCntW'(QDepth - 2));
  assign cmd_i.ready = !s1_valid_q || s1_fire;
  assign cmd_fire    = cmd_i.valid && cmd_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (cmd_i.ready) begin
      s1_valid_q <= cmd_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_fire) begin
      s1_op_q  <= opcode_e'(cmd_i.opcode);
      s1_tgt_q <= cmd_i.target_address;
      s1_dat_q <= cmd_i.data_byte;
    end
  end

  // Unknown devices read back as zero on verify, whatever the bus shows.
  assign verify_byte = (type_class(dev_q) == ClsUnknown) ? '0 : s1_dat_q;
  assign over_len    = LenW'(att_q) * LenW'(OVERPROGRAM_FACTOR);
  assign over_ms     = (over_len > LenW'(MsMax)) ? MsMax : over_len[MsW-1:0];
  assign give_up     = ({1'b0, att_q} + 6'd1) >= 6'(MAX_ATTEMPTS);

  always_comb begin
    addr_d   = addr_q;
    phase_d  = phase_q;
    att_d    = att_q;
    ms_d     = ms_q;
    wanted_d = wanted_q;
    sample_d = sample_q;
    n_res    = 2'd0;
    r0       = '0;
    r1       = '0;
    if (s1_fire) begin
      case (s1_op_q)
        OpSeek: begin
          if (phase_q == PhIdle) begin
            addr_d = s1_tgt_q;
            n_res  = 2'd1;
            r0     = make_result(ActAddr, dev_q, s1_tgt_q, wanted_q, '0, 1'b0, 1'b1);
          end
        end
        OpNext: begin
          if (phase_q == PhIdle) begin
            addr_d = addr_q + AddrW'(1);
            n_res  = 2'd1;
            r0     = make_result(ActAddr, dev_q, addr_d, wanted_q, '0, 1'b0, 1'b1);
          end
        end
        OpRead: begin
          if (phase_q == PhIdle) begin
            phase_d = PhRead;
            n_res   = 2'd1;
            r0      = make_result(ActRead, dev_q, addr_q, wanted_q, '0, 1'b0, 1'b1);
          end
        end
        OpWrite: begin
          if (phase_q == PhIdle) begin
            wanted_d = s1_dat_q;
            phase_d  = PhCheck;
            n_res    = 2'd1;
            r0       = make_result(ActRead, dev_q, addr_q, s1_dat_q, '0, 1'b0, 1'b1);
          end
        end
        OpSample: begin
          if (phase_q == PhRead) begin
            sample_d = s1_dat_q;
            phase_d  = PhIdle;
            n_res    = 2'd1;
            r0       = make_result(ActDone, dev_q, addr_q, wanted_q, s1_dat_q, 1'b0, 1'b1);
          end else if (phase_q == PhCheck) begin
            sample_d = s1_dat_q;
            n_res    = 2'd1;
            if (s1_dat_q == wanted_q) begin
              // Cell already holds the byte: finish without pulsing.
              phase_d = PhIdle;
              r0 = make_result(ActDone, dev_q, addr_q, wanted_q, s1_dat_q, 1'b0, 1'b1);
            end else begin
              att_d   = AttW'(1);
              ms_d    = MsW'(1);
              phase_d = PhPulse;
              r0 = make_result(ActOn, dev_q, addr_q, wanted_q, '0, 1'b0, 1'b1);
            end
          end else if (phase_q == PhVerify) begin
            sample_d = verify_byte;
            n_res    = 2'd1;
            if (verify_byte == wanted_q) begin
              // Verified: start the overprogram pulse.
              ms_d    = over_ms;
              phase_d = PhOver;
              r0 = make_result(ActOn, dev_q, addr_q, wanted_q, '0, 1'b0, 1'b1);
            end else if (give_up) begin
              phase_d = PhIdle;
              r0 = make_result(ActDone, dev_q, addr_q, wanted_q, verify_byte, 1'b1, 1'b1);
            end else begin
              att_d   = att_q + AttW'(1);
              ms_d    = MsW'(1);
              phase_d = PhPulse;
              r0 = make_result(ActOn, dev_q, addr_q, wanted_q, '0, 1'b0, 1'b1);
            end
          end
        end
        OpTick: begin
          if (phase_q == PhPulse || phase_q == PhOver) begin
            if (ms_q > MsW'(1)) begin
              ms_d = ms_q - MsW'(1);
            end else begin
              // Pulse ends: drop it, then verify or report.
              ms_d  = '0;
              n_res = 2'd2;
              r0 = make_result(ActOff, dev_q, addr_q, wanted_q, '0, 1'b0, 1'b0);
              if (phase_q == PhPulse) begin
                phase_d = PhVerify;
                r1 = make_result(ActVerify, dev_q, addr_q, wanted_q, '0, 1'b0, 1'b1);
              end else begin
                phase_d = PhIdle;
                r1 = make_result(ActDone, dev_q, addr_q, wanted_q, sample_q, 1'b0, 1'b1);
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_q    <= TypeUnknown;
      addr_q   <= '0;
      phase_q  <= PhIdle;
      att_q    <= AttW'(1);
      ms_q     <= '0;
      wanted_q <= '0;
      sample_q <= '0;
    end else begin
      if (cfg_we_i) begin
        dev_q <= cfg_wdata_i;
      end
      addr_q   <= addr_d;
      phase_q  <= phase_d;
      att_q    <= att_d;
      ms_q     <= ms_d;
      wanted_q <= wanted_d;
      sample_q <= sample_d;
    end
  end

  assign q_ctrl.push_cnt = n_res;
  assign q_ctrl.pop      = pop;

  eps_result_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (q_ctrl),
    .push0_i (r0),
    .push1_i (r1),
    .head_o  (head),
    .count_o (q_count)
  );

  assign res_o.valid           = (q_count != '0);
  assign res_o.action          = head.action;
  assign res_o.drive_data      = head.drive_data;
  assign res_o.address_out     = head.address_out;
  assign res_o.high_port       = head.high_port;
  assign res_o.chip_enable_n   = head.chip_enable_n;
  assign res_o.output_enable_n = head.output_enable_n;
  assign res_o.program_n       = head.program_n;
  assign res_o.result_byte     = head.result_byte;
  assign res_o.failed          = head.failed;
  assign res_o.last_of_run     = head.last_of_run;

  // Queue never overfills.
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= QCntW'(QDepth))
    else $error("result queue overflow");

  // Commands are dropped while a read or write is in progress.
  a_busy_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && phase_q != PhIdle &&
    (s1_op_q == OpSeek || s1_op_q == OpNext || s1_op_q == OpRead || s1_op_q == OpWrite)
    |-> n_res == 2'd0)
    else $error("command produced a result while busy");

  // A pulse timer only runs during a pulse.
  a_ms_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PhPulse && phase_q != PhOver) |-> ms_q == '0)
    else $error("pulse timer running outside a pulse");

  // The last tick of a pulse yields pulse off plus a follow-up.
  a_pulse_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_op_q == OpTick && (phase_q == PhPulse || phase_q == PhOver) &&
    ms_q <= MsW'(1) |-> n_res == 2'd2 && r0.action == ActOff)
    else $error("pulse end did not give two results");

endmodule
